// ----- rtl/kcbf_pkg.sv -----
// types and constants for the key to character best-fit lookup block
// used by kcbf_if users and by key_to_char_best_fit; no dependencies
package kcbf_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_HDR  = 2'd0,
    ACT_LOAD_CHAR = 2'd1,
    ACT_LOOKUP    = 2'd2
  } action_e;

  localparam logic CFG_LEVEL_MODS = 1'b0;
  localparam logic CFG_LAYOUT     = 1'b1;

  localparam logic [7:0] MOD_SHIFT = 8'h01;
  localparam logic [7:0] MOD_CTRL  = 8'h02;
  localparam logic [7:0] MOD_ALT   = 8'h04;
  localparam logic [7:0] MOD_KANA  = 8'h08;
  localparam logic [7:0] MOD_ALTGR = MOD_CTRL | MOD_ALT;

  localparam int unsigned ATTR_CAPLOK  = 0;
  localparam int unsigned ATTR_SGCAPS  = 1;
  localparam int unsigned ATTR_CAPALTGR = 2;
  localparam int unsigned ATTR_KANALOK = 3;

  localparam int unsigned LOCK_CAPS = 0;
  localparam int unsigned LOCK_KANA = 3;

  localparam logic [15:0] CH_NONE = 16'hF000;
  localparam logic [15:0] CH_DEAD = 16'hF001;
  localparam logic [15:0] CH_LGTR = 16'hF002;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  key;
    logic        present;
    logic [3:0]  attributes;
    logic [3:0]  level_count;
    logic [2:0]  level;
    logic        row;
    logic [15:0] char_value;
    logic [7:0]  held_mods;
    logic [3:0]  lock_state;
  } req_t;

  typedef struct packed {
    logic [15:0] character;
    logic [7:0]  consumed_mods;
    logic        dead;
  } rsp_t;

endpackage

// ----- rtl/kcbf_if.sv -----
// valid/ready channel carrying one item of a given payload type
// no dependencies
interface kcbf_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/key_to_char_best_fit.sv -----
// key to character best-fit lookup over a loaded keyboard layout
// depends on kcbf_pkg and kcbf_if
//
// Header and character loads give no result. A lookup reads the key header,
// then the character memories at one level per cycle for each of its N levels
// (N being the key's level count, at most MAX_LEVELS) while a single compare
// unit keeps the best level so far; its result is offered once the output
// register is free. The block is not ready during a lookup; a finished result
// waits in the output register while new loads are taken.
module key_to_char_best_fit #(
  parameter int unsigned KEY_CODES  = 256,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  kcbf_if.sink        req_i,
  kcbf_if.source      rsp_o
);

  localparam int unsigned KEY_W  = $clog2(KEY_CODES);
  localparam int unsigned LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CDEPTH = KEY_CODES * (2 ** LVL_W);
  localparam int unsigned CADR_W = KEY_W + LVL_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [3:0]       attr;
    logic [CNT_W-1:0] cnt;
  } hdr_t;

  state_e state_q, state_d;

  logic [63:0] lvl_mods_q;
  logic        layout_q;

  logic [KEY_CODES-1:0] present_q;
  hdr_t                 hdr_mem [KEY_CODES];
  hdr_t                 hdr_rd_q;
  logic [15:0]          prim_mem [CDEPTH];
  logic [15:0]          alt_mem [CDEPTH];
  logic [15:0]          prim_rd_q;
  logic [15:0]          alt_rd_q;

  logic [KEY_W-1:0] key_q;
  logic [7:0]       mods_q;
  logic [3:0]       locks_q;
  logic             hit_q;
  logic             sgcaps_q;
  logic [CNT_W-1:0] nlev_q;
  logic [LVL_W-1:0] lv_q;

  logic             found_q;
  logic [3:0]       score_q;
  logic [15:0]      best_char_q;
  logic [7:0]       best_mods_q;
  logic             best_dead_q;

  logic             out_valid_q;
  kcbf_pkg::rsp_t   out_q;

  // request decode
  kcbf_pkg::req_t   req;
  logic             accept;
  logic             key_ok;
  logic             lvl_ok;
  logic [KEY_W-1:0] req_key;
  logic [3:0]       req_lvl4;
  logic [CADR_W-1:0] wr_addr;
  logic [CNT_W-1:0] cnt_ext;
  logic [CNT_W-1:0] cnt_sat;

  assign req      = req_i.data;
  assign accept   = req_i.valid && req_i.ready;
  assign key_ok   = {1'b0, req.key} < 9'(KEY_CODES);
  assign lvl_ok   = 5'(req.level) < 5'(MAX_LEVELS);
  assign req_key  = req.key[KEY_W-1:0];
  assign req_lvl4 = 4'(req.level);
  assign wr_addr  = {req_key, req_lvl4[LVL_W-1:0]};
  assign cnt_ext  = CNT_W'(req.level_count);
  assign cnt_sat  = (cnt_ext > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : cnt_ext;

  assign req_i.ready = (state_q == ST_IDLE);

  // lock handling on the header
  logic [7:0] m1, m2, m3;
  always_comb begin
    m1 = mods_q;
    if (hdr_rd_q.attr[kcbf_pkg::ATTR_CAPLOK] && ((mods_q & ~kcbf_pkg::MOD_SHIFT) == 8'h00)
        && locks_q[kcbf_pkg::LOCK_CAPS]) begin
      m1 = mods_q ^ kcbf_pkg::MOD_SHIFT;
    end
    m2 = m1;
    if (hdr_rd_q.attr[kcbf_pkg::ATTR_CAPALTGR] && ((m1 & kcbf_pkg::MOD_ALTGR) != 8'h00)
        && locks_q[kcbf_pkg::LOCK_CAPS]) begin
      m2 = m1 ^ kcbf_pkg::MOD_SHIFT;
    end
    m3 = m2;
    if (hdr_rd_q.attr[kcbf_pkg::ATTR_KANALOK] && locks_q[kcbf_pkg::LOCK_KANA]) begin
      m3 = m2 ^ kcbf_pkg::MOD_KANA;
    end
  end

  // level evaluation, one level per cycle
  logic [3:0]  lv4;
  logic [7:0]  need;
  logic        lvl_usable;
  logic        use_alt;
  logic [15:0] cand;
  logic        cand_ok;
  logic [3:0]  score;
  logic        take;
  logic        last_lvl;

  assign lv4        = 4'(lv_q);
  assign need       = lv4[3] ? 8'h00 : lvl_mods_q[8*lv4[2:0] +: 8];
  assign lvl_usable = ((need & ~mods_q) == 8'h00) &&
                      !(((need & kcbf_pkg::MOD_CTRL) != 8'h00) &&
                        ((need & kcbf_pkg::MOD_ALT) == 8'h00));
  assign use_alt    = (prim_rd_q == kcbf_pkg::CH_DEAD) || sgcaps_q;
  assign cand       = use_alt ? alt_rd_q : prim_rd_q;
  assign cand_ok    = (cand != kcbf_pkg::CH_DEAD) && (cand != kcbf_pkg::CH_LGTR) &&
                      (cand != kcbf_pkg::CH_NONE);
  assign score      = 4'($countones(need & mods_q));
  assign take       = lvl_usable && cand_ok && (!found_q || (score > score_q));
  assign last_lvl   = (CNT_W'(lv_q) + CNT_W'(1)) == nlev_q;

  // character memory read address
  logic [LVL_W-1:0]  rd_lvl;
  logic [CADR_W-1:0] rd_addr;
  assign rd_lvl  = (state_q == ST_SCAN) ? lv_q + LVL_W'(1) : '0;
  assign rd_addr = {key_q, rd_lvl};

  logic out_free;
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req.action == kcbf_pkg::ACT_LOOKUP)) begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (!hit_q || (hdr_rd_q.cnt == '0)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_lvl) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_mods_q  <= '0;
      layout_q    <= 1'b0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kcbf_pkg::CFG_LEVEL_MODS: lvl_mods_q <= cfg_wdata_i;
          kcbf_pkg::CFG_LAYOUT:     layout_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept && (req.action == kcbf_pkg::ACT_LOAD_HDR) && key_ok) begin
        present_q[req_key] <= req.present;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // layout memories
  always_ff @(posedge clk_i) begin
    if (accept && (req.action == kcbf_pkg::ACT_LOAD_HDR) && key_ok) begin
      hdr_mem[req_key] <= '{attr: req.attributes, cnt: cnt_sat};
    end
    hdr_rd_q <= hdr_mem[req_key];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req.action == kcbf_pkg::ACT_LOAD_CHAR) && key_ok && lvl_ok && !req.row) begin
      prim_mem[wr_addr] <= req.char_value;
    end
    prim_rd_q <= prim_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req.action == kcbf_pkg::ACT_LOAD_CHAR) && key_ok && lvl_ok && req.row) begin
      alt_mem[wr_addr] <= req.char_value;
    end
    alt_rd_q <= alt_mem[rd_addr];
  end

  // lookup datapath
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && accept) begin
      key_q   <= req_key;
      mods_q  <= req.held_mods;
      locks_q <= req.lock_state;
      hit_q   <= layout_q && key_ok && present_q[req_key];
    end
    if (state_q == ST_HDR) begin
      mods_q      <= m3;
      sgcaps_q    <= hdr_rd_q.attr[kcbf_pkg::ATTR_SGCAPS] && locks_q[kcbf_pkg::LOCK_CAPS];
      nlev_q      <= hdr_rd_q.cnt;
      lv_q        <= '0;
      found_q     <= 1'b0;
      score_q     <= '0;
      best_char_q <= kcbf_pkg::CH_NONE;
      best_mods_q <= '0;
      best_dead_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      lv_q <= lv_q + LVL_W'(1);
      if (take) begin
        found_q     <= 1'b1;
        score_q     <= score;
        best_char_q <= cand;
        best_mods_q <= need;
        best_dead_q <= use_alt;
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.character     <= best_char_q;
      out_q.consumed_mods <= best_mods_q;
      out_q.dead          <= best_dead_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ----- bench/key_to_char_best_fit_test.sv -----
// self-checking bench for key_to_char_best_fit: layout loads, lookups, register phases
// predicts untyped lookup answers from a shadow layout; depends on kcbf_pkg, kcbf_if and the rtl
module key_to_char_best_fit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS          = 8;
  localparam int unsigned SETTLE          = LEVELS + 8;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned ITEMS_PER_PHASE = 208;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  localparam logic [63:0] DEMO_LEVELS     = 64'h09FF_0807_0602_0100;
  localparam kcbf_pkg::rsp_t NO_FIT       = {kcbf_pkg::CH_NONE, 8'h00, 1'b0};

  typedef struct {
    bit             is_cfg;
    logic           cfg_idx;
    logic [63:0]    cfg_val;
    kcbf_pkg::req_t item;
    bit             typed;
    kcbf_pkg::rsp_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  kcbf_if #(.payload_t(kcbf_pkg::req_t)) req_if ();
  kcbf_if #(.payload_t(kcbf_pkg::rsp_t)) rsp_if ();

  key_to_char_best_fit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow copy of the layout table and registers
  bit          hdr_present [256];
  logic [3:0]  hdr_attr    [256];
  int unsigned hdr_levels  [256];
  logic [15:0] glyph       [256][LEVELS][2];
  bit          glyph_set   [256][LEVELS][2];
  logic [63:0] level_mods;
  bit          layout_on;

  kcbf_pkg::rsp_t fit_answers [$];
  plan_row_t      plan [$];
  int unsigned    mismatches;
  int unsigned    cycles;
  int unsigned    sent;
  int unsigned    idle_pct;
  int unsigned    stall_pct;

  always #1 clk_i = ~clk_i;

  function automatic kcbf_pkg::rsp_t best_fit_char(input kcbf_pkg::req_t it);
    kcbf_pkg::rsp_t r;
    logic [7:0]     held;
    logic [7:0]     need;
    logic [3:0]     attr;
    logic [15:0]    c;
    bit             sg;
    bit             from_alt;
    bit             found;
    int unsigned    score;
    int unsigned    best;
    r     = NO_FIT;
    found = 1'b0;
    best  = 0;
    if (!layout_on || !hdr_present[it.key]) return r;
    attr = hdr_attr[it.key];
    held = it.held_mods;
    if (attr[kcbf_pkg::ATTR_CAPLOK] && (held & ~kcbf_pkg::MOD_SHIFT) == 8'h00 &&
        it.lock_state[kcbf_pkg::LOCK_CAPS])
      held ^= kcbf_pkg::MOD_SHIFT;
    if (attr[kcbf_pkg::ATTR_CAPALTGR] && (held & kcbf_pkg::MOD_ALTGR) != 8'h00 &&
        it.lock_state[kcbf_pkg::LOCK_CAPS])
      held ^= kcbf_pkg::MOD_SHIFT;
    sg = attr[kcbf_pkg::ATTR_SGCAPS] && it.lock_state[kcbf_pkg::LOCK_CAPS];
    if (attr[kcbf_pkg::ATTR_KANALOK] && it.lock_state[kcbf_pkg::LOCK_KANA])
      held ^= kcbf_pkg::MOD_KANA;
    for (int lv = 0; lv < int'(hdr_levels[it.key]); lv++) begin
      need = level_mods[8 * lv +: 8];
      if ((need & ~held) != 8'h00) continue;
      if ((need & kcbf_pkg::MOD_CTRL) != 8'h00 && (need & kcbf_pkg::MOD_ALT) == 8'h00) continue;
      c        = glyph[it.key][lv][0];
      from_alt = 1'b0;
      if (c == kcbf_pkg::CH_DEAD || sg) begin
        c        = glyph[it.key][lv][1];
        from_alt = 1'b1;
      end
      if (c == kcbf_pkg::CH_DEAD || c == kcbf_pkg::CH_LGTR || c == kcbf_pkg::CH_NONE) continue;
      score = $countones(need & held);
      if (!found || score > best) begin
        found           = 1'b1;
        best            = score;
        r.character     = c;
        r.consumed_mods = need;
        r.dead          = from_alt;
      end
    end
    return r;
  endfunction

  // a lookup may only touch character entries that have been written
  function automatic bit key_safe(input logic [7:0] k);
    if (!hdr_present[k]) return 1'b1;
    for (int lv = 0; lv < int'(hdr_levels[k]); lv++)
      if (!glyph_set[k][lv][0] || !glyph_set[k][lv][1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic kcbf_pkg::req_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return kcbf_pkg::req_t'(raw[$bits(kcbf_pkg::req_t)-1:0]);
  endfunction

  function automatic kcbf_pkg::req_t hdr_item(input kcbf_pkg::req_t it, input logic [7:0] k,
                                              input logic p, input logic [3:0] a,
                                              input logic [3:0] n);
    it.action      = kcbf_pkg::ACT_LOAD_HDR;
    it.key         = k;
    it.present     = p;
    it.attributes  = a;
    it.level_count = n;
    return it;
  endfunction

  function automatic kcbf_pkg::req_t char_item(input kcbf_pkg::req_t it, input logic [7:0] k,
                                               input logic [2:0] lv, input logic r,
                                               input logic [15:0] v);
    it.action     = kcbf_pkg::ACT_LOAD_CHAR;
    it.key        = k;
    it.level      = lv;
    it.row        = r;
    it.char_value = v;
    return it;
  endfunction

  function automatic kcbf_pkg::req_t lookup_item(input kcbf_pkg::req_t it, input logic [7:0] k,
                                                 input logic [7:0] m, input logic [3:0] l);
    it.action     = kcbf_pkg::ACT_LOOKUP;
    it.key        = k;
    it.held_mods  = m;
    it.lock_state = l;
    return it;
  endfunction

  function automatic plan_row_t cfg_row(input logic idx, input logic [63:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.item    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t item_row(input kcbf_pkg::req_t it, input bit typed = 1'b0,
                                         input kcbf_pkg::rsp_t want = '0);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = 1'b0;
    r.cfg_val = '0;
    r.item    = it;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15) * 17);
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_glyph();
    case ($urandom_range(0, 9))
      0: return kcbf_pkg::CH_DEAD;
      1: return kcbf_pkg::CH_LGTR;
      2: return kcbf_pkg::CH_NONE;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_mods();
    int unsigned lv;
    logic [7:0]  m;
    lv = $urandom_range(0, LEVELS - 1);
    m  = level_mods[8 * lv +: 8];
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return m;
      2: return m | (8'h01 << $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [63:0] any_level_mods();
    logic [63:0] v;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 7))
        0: v[8 * b +: 8] = 8'h00;
        1: v[8 * b +: 8] = kcbf_pkg::MOD_SHIFT;
        2: v[8 * b +: 8] = kcbf_pkg::MOD_ALTGR;
        3: v[8 * b +: 8] = kcbf_pkg::MOD_ALTGR | kcbf_pkg::MOD_SHIFT;
        4: v[8 * b +: 8] = kcbf_pkg::MOD_KANA;
        5: v[8 * b +: 8] = kcbf_pkg::MOD_KANA | kcbf_pkg::MOD_SHIFT;
        6: v[8 * b +: 8] = kcbf_pkg::MOD_CTRL;
        default: v[8 * b +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  task automatic note_miss(input string what, input kcbf_pkg::rsp_t want,
                           input kcbf_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s: expected char %h mods %h dead %b, got char %h mods %h dead %b",
               what, want.character, want.consumed_mods, want.dead,
               got.character, got.consumed_mods, got.dead);
  endtask

  task automatic send_item(input kcbf_pkg::req_t it, input bit typed = 1'b0,
                           input kcbf_pkg::rsp_t want = '0);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    case (it.action)
      kcbf_pkg::ACT_LOAD_HDR: begin
        hdr_present[it.key] = it.present;
        hdr_attr[it.key]    = it.attributes;
        hdr_levels[it.key]  = (it.level_count > LEVELS) ? LEVELS : it.level_count;
      end
      kcbf_pkg::ACT_LOAD_CHAR: begin
        glyph[it.key][it.level][it.row]     = it.char_value;
        glyph_set[it.key][it.level][it.row] = 1'b1;
      end
      kcbf_pkg::ACT_LOOKUP: fit_answers.push_back(typed ? want : best_fit_char(it));
      default: ;
    endcase
    if (it.action != ACT_UNUSED) sent++;
  endtask

  task automatic write_cfg(input logic idx, input logic [63:0] val);
    req_if.valid <= 1'b0;
    while (fit_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == kcbf_pkg::CFG_LEVEL_MODS) level_mods = val;
    else layout_on = val[0];
  endtask

  // header, each unwritten character of its levels and some rewrites, then one to four lookups on the same key
  task automatic layout_sequence();
    logic [7:0]  k;
    logic [3:0]  n;
    int unsigned used;
    k = pick_key();
    n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                    : 4'($urandom_range(1, LEVELS));
    send_item(hdr_item(rand_item(), k, 1'b1, 4'($urandom), n));
    used = (n > LEVELS) ? LEVELS : n;
    for (int lv = 0; lv < int'(used); lv++)
      for (int r = 0; r < 2; r++)
        if (!glyph_set[k][lv][r] || $urandom_range(0, 1) == 0)
          send_item(char_item(rand_item(), k, 3'(lv), 1'(r), pick_glyph()));
    repeat ($urandom_range(1, 4))
      send_item(lookup_item(rand_item(), k, pick_mods(), 4'($urandom)));
  endtask

  task automatic noise_item();
    kcbf_pkg::req_t it;
    bit             fixed;
    it    = rand_item();
    fixed = 1'b0;
    if (it.action == kcbf_pkg::ACT_LOOKUP && !key_safe(it.key)) begin
      for (int lv = 0; lv < int'(LEVELS); lv++)
        for (int r = 0; r < 2; r++)
          if (!fixed && !glyph_set[it.key][lv][r]) begin
            it.action = kcbf_pkg::ACT_LOAD_CHAR;
            it.level  = 3'(lv);
            it.row    = 1'(r);
            fixed     = 1'b1;
          end
    end
    send_item(it);
  endtask

  task automatic run_phase(input logic [63:0] mods_cfg, input bit layout_cfg,
                           input int unsigned idle, input int unsigned stall);
    int unsigned target;
    write_cfg(kcbf_pkg::CFG_LEVEL_MODS, mods_cfg);
    write_cfg(kcbf_pkg::CFG_LAYOUT, {63'd0, layout_cfg});
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent + ITEMS_PER_PHASE;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7) layout_sequence();
      else noise_item();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (fit_answers.size() == 0) begin
        note_miss("unexpected item", NO_FIT, rsp_if.data);
      end else begin
        if (rsp_if.data.character !== fit_answers[0].character ||
            rsp_if.data.consumed_mods !== fit_answers[0].consumed_mods ||
            rsp_if.data.dead !== fit_answers[0].dead)
          note_miss("mismatch", fit_answers[0], rsp_if.data);
        void'(fit_answers.pop_front());
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("key_to_char_best_fit regression: fail");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = kcbf_pkg::CFG_LEVEL_MODS;
    cfg_wdata_i  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    level_mods   = '0;
    layout_on    = 1'b0;

    plan.push_back(item_row(lookup_item('0, 8'h00, 8'h00, 4'h0), 1'b1, NO_FIT));
    plan.push_back(cfg_row(kcbf_pkg::CFG_LAYOUT, 64'd1));
    plan.push_back(item_row(lookup_item('0, 8'h00, 8'hFF, 4'hF), 1'b1, NO_FIT));
    plan.push_back(cfg_row(kcbf_pkg::CFG_LEVEL_MODS, DEMO_LEVELS));
    // caps lock and caps lock with altgr, four levels one of them ctrl only
    plan.push_back(item_row(hdr_item('0, 8'h41, 1'b1, 4'b0101, 4'd4)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd0, 1'b0, 16'h0061)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd0, 1'b1, 16'h0000)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd1, 1'b0, 16'h0041)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd1, 1'b1, 16'hFFFF)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd2, 1'b0, kcbf_pkg::CH_NONE)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd2, 1'b1, 16'h0063)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd3, 1'b0, kcbf_pkg::CH_DEAD)));
    plan.push_back(item_row(char_item('0, 8'h41, 3'd3, 1'b1, 16'h00E4)));
    plan.push_back(item_row(lookup_item('0, 8'h41, 8'h00, 4'h0)));
    plan.push_back(item_row(lookup_item('0, 8'h41, kcbf_pkg::MOD_SHIFT, 4'h0)));
    plan.push_back(item_row(lookup_item('0, 8'h41, 8'h00, 4'h1)));
    plan.push_back(item_row(lookup_item('0, 8'h41, kcbf_pkg::MOD_ALTGR, 4'h1)));
    plan.push_back(item_row(lookup_item('0, 8'h41, 8'hFF, 4'hF)));
    plan.push_back(item_row({ACT_UNUSED, {($bits(kcbf_pkg::req_t) - 2){1'b1}}}));
    // sgcaps and kana lock key, ligature in the primary row
    plan.push_back(item_row(hdr_item('0, 8'hFF, 1'b1, 4'b1010, 4'd1)));
    plan.push_back(item_row(char_item('0, 8'hFF, 3'd0, 1'b0, kcbf_pkg::CH_LGTR)));
    plan.push_back(item_row(char_item('0, 8'hFF, 3'd0, 1'b1, 16'h3042)));
    plan.push_back(item_row(lookup_item('0, 8'hFF, 8'h00, 4'h0), 1'b1, NO_FIT));
    plan.push_back(item_row(lookup_item('0, 8'hFF, 8'h00, 4'h1)));
    plan.push_back(item_row(lookup_item('0, 8'hFF, 8'h00, 4'h9)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
      else send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    run_phase(64'h0, 1'b1, 63, 0);
    run_phase({64{1'b1}}, 1'b1, 0, 63);
    run_phase(DEMO_LEVELS, 1'b1, 26, 26);
    run_phase(any_level_mods(), 1'b0, 0, 0);
    run_phase(any_level_mods(), 1'b1, 63, 0);
    run_phase(any_level_mods(), 1'b1, 0, 63);
    run_phase(any_level_mods(), 1'b1, 26, 26);

    req_if.valid <= 1'b0;
    while (fit_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("key_to_char_best_fit regression: pass");
    end else begin
      $display("key_to_char_best_fit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kcbf_pkg.sv
rtl/kcbf_if.sv
rtl/key_to_char_best_fit.sv
bench/key_to_char_best_fit_test.sv
